// ===== src/magma_pkg.sv =====
// Shared types, constants and round functions for the Magma block cipher.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package magma_pkg;

	localparam int unsigned NUM_ROUNDS = 32;
	localparam int unsigned KEY_WORDS = 8;
	localparam int unsigned HALF_W = 32;
	localparam int unsigned BLOCK_W = 64;
	localparam int unsigned ROT_AMT = 11;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned KIDX_W = 3;

	typedef logic [HALF_W-1:0] half_t;
	typedef half_t [KEY_WORDS-1:0] key_arr_t;

	// One block in flight: x feeds the next round, y is updated by it.
	typedef struct packed {
		logic op;
		half_t x;
		half_t y;
	} mg_blk_t;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	typedef logic [3:0] nib_t;
	typedef nib_t [15:0] sbox_row_t;
	typedef sbox_row_t [7:0] sbox_t;

	// S-box i (row i) serves nibble i, counted from the least significant end.
	// Both types are packed, so rows and entries are listed from the highest
	// index down.
	localparam sbox_t SBOX = '{
		'{4'd2, 4'd11, 4'd12, 4'd9, 4'd6, 4'd10, 4'd15, 4'd4,
		  4'd3, 4'd8, 4'd5, 4'd0, 4'd13, 4'd14, 4'd7, 4'd1},
		'{4'd7, 4'd3, 4'd10, 4'd13, 4'd0, 4'd11, 4'd4, 4'd15,
		  4'd12, 4'd1, 4'd9, 4'd6, 4'd5, 4'd2, 4'd14, 4'd8},
		'{4'd0, 4'd14, 4'd3, 4'd4, 4'd1, 4'd8, 4'd7, 4'd11,
		  4'd10, 4'd12, 4'd2, 4'd9, 4'd6, 4'd15, 4'd13, 4'd5},
		'{4'd12, 4'd2, 4'd4, 4'd11, 4'd14, 4'd3, 4'd9, 4'd0,
		  4'd13, 4'd6, 4'd1, 4'd8, 4'd10, 4'd5, 4'd15, 4'd7},
		'{4'd11, 4'd9, 4'd14, 4'd3, 4'd5, 4'd10, 4'd0, 4'd7,
		  4'd6, 4'd15, 4'd4, 4'd13, 4'd1, 4'd2, 4'd8, 4'd12},
		'{4'd0, 4'd6, 4'd9, 4'd12, 4'd4, 4'd7, 4'd1, 4'd14,
		  4'd13, 4'd10, 4'd15, 4'd2, 4'd8, 4'd5, 4'd3, 4'd11},
		'{4'd15, 4'd0, 4'd13, 4'd11, 4'd7, 4'd4, 4'd14, 4'd1,
		  4'd12, 4'd5, 4'd10, 4'd9, 4'd3, 4'd2, 4'd8, 4'd6},
		'{4'd1, 4'd15, 4'd3, 4'd0, 4'd7, 4'd13, 4'd8, 4'd14,
		  4'd9, 4'd11, 4'd5, 4'd10, 4'd2, 4'd6, 4'd4, 4'd12}
	};

	// Nibble substitution followed by the left rotation.
	function automatic half_t round_f(input half_t v);
		half_t s;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s[4*i +: 4] = SBOX[i][v[4*i +: 4]];
		end
		return (s << ROT_AMT) | (s >> (HALF_W - ROT_AMT));
	endfunction

	// Key word used in round r: forward order for the first rounds,
	// reverse order afterwards.
	function automatic logic [KIDX_W-1:0] key_idx(input int unsigned r, input logic dec);
		int unsigned fwd;
		logic [KIDX_W-1:0] low;
		fwd = (dec == OP_DECRYPT) ? 8 : 24;
		low = KIDX_W'(r % KEY_WORDS);
		return (r < fwd) ? low : (KIDX_W'(KEY_WORDS - 1) - low);
	endfunction

endpackage

`default_nettype wire

// ===== src/magma_if.sv =====
// Valid/ready channel interfaces for the block input and the result.
// Depends on magma_pkg for the field widths.
`default_nettype none

interface magma_in_if;
	import magma_pkg::*;
	logic valid;
	logic ready;
	logic op;
	logic [BLOCK_W-1:0] block_in;
	modport source(output valid, output op, output block_in, input ready);
	modport sink(input valid, input op, input block_in, output ready);
endinterface

interface magma_out_if;
	import magma_pkg::*;
	logic valid;
	logic ready;
	logic [BLOCK_W-1:0] block_out;
	modport source(output valid, output block_out, input ready);
	modport sink(input valid, input block_out, output ready);
endinterface

`default_nettype wire

// ===== src/magma_cfg.sv =====
// APB-style register file holding the eight 32-bit key words.
// Depends on magma_pkg.
`default_nettype none

module magma_cfg
	import magma_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [HALF_W-1:0] pwdata,
	output logic      [HALF_W-1:0] prdata,
	output logic                   pready,
	output key_arr_t               key
);

	key_arr_t key_q;
	logic [KIDX_W-1:0] widx;
	logic wr_en;

	// Word addressing: byte address 4*i selects key word i.
	assign widx = paddr[ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	// Key registers are written in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (wr_en) begin
			key_q[widx] <= pwdata;
		end
	end

	assign prdata = key_q[widx];
	assign key = key_q;

endmodule

`default_nettype wire

// ===== src/magma_round.sv =====
// One Feistel round of the cipher with its pipeline register.
// Depends on magma_pkg.
`default_nettype none

module magma_round
	import magma_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    en,
	input  wire logic    valid_in,
	input  mg_blk_t      blk_in,
	input  wire half_t   key_enc,
	input  wire half_t   key_dec,
	output logic         valid_out,
	output mg_blk_t      blk_out
);

	logic valid_s1;
	mg_blk_t blk_s1;
	half_t k;
	mg_blk_t nxt;

	// Pick the key word for the direction of this block, then run the round
	// and swap the halves.
	always_comb begin
		k = (blk_in.op == OP_DECRYPT) ? key_dec : key_enc;
		nxt.op = blk_in.op;
		nxt.x = blk_in.y ^ round_f(blk_in.x + k);
		nxt.y = blk_in.x;
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			blk_s1 <= nxt;
		end
	end

	assign valid_out = valid_s1;
	assign blk_out = blk_s1;

endmodule

`default_nettype wire

// ===== src/magma_block_cipher.sv =====
// Top level of the Magma 64-bit block cipher: key registers and round pipeline.
// Depends on magma_pkg, magma_if, magma_cfg and magma_round.
//
// Usage:
//   Input beats on blk_in carry op (0 encrypt, 1 decrypt) and a 64-bit block;
//   result beats on blk_out carry the 64-bit result, in input order.
//   The key is loaded through the APB-style port as eight 32-bit words at
//   byte addresses 0, 4, ... 28; it should be written only while no block
//   is in flight. Reads return the stored word.
//   The 32 rounds are unrolled into 32 register stages, one round each
//   (a 32-bit add, the S-boxes and an XOR), and a new block can enter every
//   cycle while the receiver is not stalling with a result waiting.
//   The last round register is the output register.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and blk_in.ready falls; nothing is dropped or repeated. Bubbles ahead of
//   an idle output move on, so a block is still taken while the output is
//   empty.
//   Reset clears the key words to zero and empties the pipeline.
`default_nettype none

module magma_block_cipher
	import magma_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	magma_in_if.sink               blk_in,
	magma_out_if.source            blk_out,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [HALF_W-1:0] pwdata,
	output logic      [HALF_W-1:0] prdata,
	output logic                   pready
);

	key_arr_t key;
	logic advance;
	logic [NUM_ROUNDS:0] stage_valid;
	mg_blk_t stage_blk [NUM_ROUNDS+1];

	magma_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.key     (key)
	);

	// The pipeline moves when the output register is empty or being taken.
	assign advance = !stage_valid[NUM_ROUNDS] || blk_out.ready;
	assign blk_in.ready = advance;

	// Feed: x starts as the low half, y as the high half.
	assign stage_valid[0] = blk_in.valid;
	assign stage_blk[0].op = blk_in.op;
	assign stage_blk[0].x = blk_in.block_in[HALF_W-1:0];
	assign stage_blk[0].y = blk_in.block_in[BLOCK_W-1:HALF_W];

	// Round stages with fixed key schedules per direction.
	for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
		localparam logic [KIDX_W-1:0] EncIdx = key_idx(r, OP_ENCRYPT);
		localparam logic [KIDX_W-1:0] DecIdx = key_idx(r, OP_DECRYPT);
		magma_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (advance),
			.valid_in  (stage_valid[r]),
			.blk_in    (stage_blk[r]),
			.key_enc   (key[EncIdx]),
			.key_dec   (key[DecIdx]),
			.valid_out (stage_valid[r+1]),
			.blk_out   (stage_blk[r+1])
		);
	end

	// After an even number of rounds x is the low half; it leads the result.
	assign blk_out.valid = stage_valid[NUM_ROUNDS];
	assign blk_out.block_out = {stage_blk[NUM_ROUNDS].x, stage_blk[NUM_ROUNDS].y};

	// The op bit travels only to pick key words; the last copy is unused.
	logic unused_op;
	assign unused_op = stage_blk[NUM_ROUNDS].op;

endmodule

`default_nettype wire
